/* rtl/htlp_pkg.sv */
// htlp_pkg: shared types and codes for the linear-probe hash table
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package htlp_pkg;

   localparam int KEY_W   = 31;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;

   // request operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // result status codes
   localparam logic [1:0] RES_OK      = 2'd0;
   localparam logic [1:0] RES_MISSING = 2'd1;
   localparam logic [1:0] RES_FULL    = 2'd2;

   // slot status codes; the third code marks a tombstone and the fourth code is never written
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_LIVE  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] result_value;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

/* rtl/htlp_home.sv */
// htlp_home: home slot unit, key modulo the table size
// power-of-two sizes take the low key bits, others a reciprocal multiply then a subtract; uses htlp_pkg
`timescale 1ns / 1ps

module htlp_home
   import htlp_pkg::*;
#(
   parameter int TABLE_SLOTS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [KEY_W-1:0]               key,
   output logic                           done,
   output logic [$clog2(TABLE_SLOTS)-1:0] home
);

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int PROD_W  = 2 * KEY_W + 1;
   localparam int SHIFT   = KEY_W + IDX_W;
   localparam bit IS_POW2 = ((1 << IDX_W) == TABLE_SLOTS);
   // rounded-up reciprocal; the quotient is exact for every key below 2**KEY_W
   localparam logic [KEY_W:0] RECIP = (KEY_W + 1)'(
      ((64'd1 << SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
   localparam logic [KEY_W-1:0] SLOTS_KEY = KEY_W'(TABLE_SLOTS);

   logic              mul_ff, mul_in;
   logic              sub_ff, sub_in;
   logic              done_ff, done_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  quot_ff, quot_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] product;
   logic [KEY_W-1:0]  quot_slots;

   assign product    = PROD_W'(key_ff) * PROD_W'(RECIP);
   // quotient times size never exceeds the key, so it fits the key width
   assign quot_slots = quot_ff * SLOTS_KEY;

   always_comb begin
      mul_in  = 1'b0;
      sub_in  = 1'b0;
      done_in = 1'b0;
      key_in  = key_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = key[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            key_in = key;
            mul_in = 1'b1;
         end
      end else if (mul_ff) begin
         quot_in = KEY_W'(product >> SHIFT);
         sub_in  = 1'b1;
      end else if (sub_ff) begin
         rem_in  = IDX_W'(key_ff - quot_slots);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

/* rtl/hash_table_linear_probe.sv */
// hash table, open addressing with linear probing; one request at a time.
// steps: accept, find the home slot, probe slots, register the result (128 slots default);
// the home slot takes a multiply then a subtract when the table size is not a power of two.
// next request waits for the result register; each probe is a memory read then a check.
// reset: synchronous; after reset a clearing pass writes every slot empty, and
// req_stall stays high until it ends.
`timescale 1ns / 1ps

module hash_table_linear_probe
   import htlp_pkg::*;
#(
   parameter int TABLE_SLOTS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [1:0]         op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   probes_ff, probes_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         status_ff, status_in;
   logic [VALUE_W-1:0] rval_ff, rval_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   entry_type          mem_q [TABLE_SLOTS];
   entry_type          rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic               home_start;
   logic               home_done;
   logic [IDX_W-1:0]   home_slot;
   logic [IDX_W-1:0]   next_addr;
   logic               last_probe;
   logic               key_match;

   htlp_home #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_home (
      .clock(clock),
      .reset(reset),
      .start(home_start),
      .key  (req_data.key),
      .done (home_done),
      .home (home_slot)
   );

   assign next_addr  = (addr_ff == LAST_SLOT) ? '0 : addr_ff + 1'b1;
   assign last_probe = (probes_ff == LAST_PROBE);
   assign key_match  = (rd_data_ff.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      addr_in      = addr_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rval_in      = rval_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      home_start   = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.operation;
               key_in  = req_data.key;
               val_in  = req_data.value;
               rval_in = '0;
               if (req_data.operation inside {OP_INSERT, OP_LOOKUP, OP_DELETE}) begin
                  home_start = 1'b1;
                  state_in   = ST_HASH;
               end else begin
                  status_in = RES_MISSING;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_HASH: begin
            if (home_done) begin
               addr_in   = home_slot;
               probes_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // read data for addr_ff lands in rd_data_ff at this edge
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (rd_data_ff.status != SLOT_LIVE || key_match) begin
                  wr_en   = 1'b1;
                  wr_data = '{status: SLOT_LIVE, key: key_ff, value: val_ff};
                  if (rd_data_ff.status != SLOT_LIVE) begin
                     count_in = count_ff + 1'b1;
                  end
                  status_in = RES_OK;
                  state_in  = ST_DONE;
               end else if (last_probe) begin
                  status_in = RES_FULL;
                  state_in  = ST_DONE;
               end else begin
                  addr_in   = next_addr;
                  probes_in = probes_ff + 1'b1;
                  state_in  = ST_READ;
               end
            end else begin
               if (rd_data_ff.status == SLOT_EMPTY) begin
                  status_in = RES_MISSING;
                  state_in  = ST_DONE;
               end else if (rd_data_ff.status == SLOT_LIVE && key_match) begin
                  status_in = RES_OK;
                  rval_in   = rd_data_ff.value;
                  if (op_ff == OP_DELETE) begin
                     wr_en   = 1'b1;
                     wr_data = '{status: SLOT_TOMB, key: rd_data_ff.key,
                                 value: rd_data_ff.value};
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  state_in = ST_DONE;
               end else if (last_probe) begin
                  status_in = RES_MISSING;
                  state_in  = ST_DONE;
               end else begin
                  addr_in   = next_addr;
                  probes_in = probes_ff + 1'b1;
                  state_in  = ST_READ;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.result_value = rval_ff;
               rsp_data_in.entry_count  = COUNT_W'(count_ff);
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      addr_ff     <= addr_in;
      probes_ff   <= probes_in;
      status_ff   <= status_in;
      rval_ff     <= rval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_q[addr_ff];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/htlp_checker.sv */
// htlp_checker: port-level checks for the hash table, bound to the top level
// uses htlp_pkg; attached by the bind statement at the end of this file
`timescale 1ns / 1ps

module htlp_checker
   import htlp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // one request at a time: an accepted beat closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after an accepted beat");

   // only ok results carry a value
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != RES_OK |-> rsp_data.result_value == '0)
      else $error("value on a result that is not ok");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == RES_OK || rsp_data.status == RES_MISSING ||
                    rsp_data.status == RES_FULL)
      else $error("unknown status code");

   // no result and no input right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_stall)
      else $error("activity right after reset");

endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (.*);
